// ===== src/sbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants of the 2x2 block solve unit
// Widths of the exact datapath, register indexes, status codes, config bundle.
// ----------------------------------------------------------------------------
package sbs_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int DW     = 32;           // data word
   localparam int PP_W   = 64;           // 32x32 product
   localparam int OP_W   = 66;           // numerator / determinant parts
   localparam int MAGO_W = 65;           // magnitude of an OP_W value
   localparam int LO_W   = 33;           // low slice of a magnitude
   localparam int HI_W   = MAGO_W - LO_W;
   localparam int MAG_W  = 2 * MAGO_W;   // product magnitude, also den
   localparam int PR_W   = MAG_W + 1;    // signed wide product
   localparam int NUM_W  = PR_W + 1;     // sum of two wide products
   localparam int QB     = 33;           // quotient bits resolved by the divider

   localparam int MUL_LAT  = 4;
   localparam int DIV_LAT  = QB + 3;
   localparam int PIPE_LAT = 3 + MUL_LAT + 1 + DIV_LAT + 1;

   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] REG_D11_RE = 3'd0;
   localparam logic [IDX_W-1:0] REG_D11_IM = 3'd1;
   localparam logic [IDX_W-1:0] REG_D21_RE = 3'd2;
   localparam logic [IDX_W-1:0] REG_D21_IM = 3'd3;
   localparam logic [IDX_W-1:0] REG_D22_RE = 3'd4;
   localparam logic [IDX_W-1:0] REG_D22_IM = 3'd5;
   localparam logic [IDX_W-1:0] REG_HERM   = 3'd6;
   localparam logic [IDX_W-1:0] REG_RSIDE  = 3'd7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SINGULAR = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   // block coefficients and values derived from them; diagonal imaginary
   // parts are already zeroed in Hermitian mode
   typedef struct packed {
      logic                    herm;
      logic                    rside;
      logic signed [DW-1:0]    d11_re;
      logic signed [DW-1:0]    d11_im;
      logic signed [DW-1:0]    d21_re;
      logic signed [DW-1:0]    d21_im;
      logic signed [DW-1:0]    d22_re;
      logic signed [DW-1:0]    d22_im;
      logic signed [OP_W-1:0]  det_re;
      logic signed [OP_W-1:0]  det_im;
      logic [MAG_W-1:0]        den;
      logic                    singular;
   } sbs_cfg_type;

   function automatic logic signed [PP_W-1:0] smul(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] y);
      return PP_W'(x) * PP_W'(y);
   endfunction

endpackage

// ===== src/symmetric_2x2_block_solve_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_2x2_block_solve_unit: inverse of a 2x2 symmetric/Hermitian block
// applied to one complex pair per cycle while busy is low, exact Q-format arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   - Load d11, d21, d22, mode and side through the csr_ write port while no
//     item is in flight; a write lands in its register at once, no read-back.
//   - An item is taken at a clock edge with start high and busy low. busy is
//     low in every cycle except during and right after reset, so one item per cycle.
//   - The result leaves on the rsp_ ports for exactly one cycle with
//     rsp_valid high, in order.
//   - The receiver cannot stall; the pipeline never holds.
// Throughput 1 item/cycle while busy is low. Depth is set by the restoring
//   divider (33 quotient-bit stages, one quotient bit per stage) behind the
//   wide multipliers (4 stages each).
// status: ok, singular (zero off-diagonal or zero determinant, all eta
//   zero), or saturated (some part clamped to the 32-bit range).
// Reset clears the coefficient registers and the valid pipe; items in
//   flight are dropped. Derived values follow through the sbs_cfg pipeline.
// ----------------------------------------------------------------------------
module symmetric_2x2_block_solve_unit import sbs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [DW-1:0] req_alpha1_re,
   input  logic signed [DW-1:0] req_alpha1_im,
   input  logic signed [DW-1:0] req_alpha2_re,
   input  logic signed [DW-1:0] req_alpha2_im,
   input  logic                 csr_we,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [DW-1:0]        csr_wdata,
   output logic                 rsp_valid,
   output logic signed [DW-1:0] rsp_eta1_re,
   output logic signed [DW-1:0] rsp_eta1_im,
   output logic signed [DW-1:0] rsp_eta2_re,
   output logic signed [DW-1:0] rsp_eta2_im,
   output logic [1:0]           rsp_status
);

   sbs_cfg_type cfg;

   logic                   busy_ff;
   logic                   accept;
   logic [PIPE_LAT-1:0]    vld_ff;

   // stage 0: input item
   logic signed [DW-1:0]   a1r_ff, a1i_ff, a2r_ff, a2i_ff;

   // stage 1: 32x32 products
   logic signed [PP_W-1:0] m22r1r_ff, m22i1i_ff, m22r1i_ff, m22i1r_ff;
   logic signed [PP_W-1:0] mor2r_ff, moi2i_ff, mor2i_ff, moi2r_ff;
   logic signed [PP_W-1:0] m11r2r_ff, m11i2i_ff, m11r2i_ff, m11i2r_ff;
   logic signed [PP_W-1:0] mor1r_ff, moi1i_ff, mor1i_ff, moi1r_ff;
   logic                   cj1_ff, cj2_ff;

   // stage 2: numerators of the adjugate product
   logic signed [OP_W-1:0] n1r_in, n1i_in, n2r_in, n2i_in;
   logic signed [OP_W-1:0] n1r_ff, n1i_ff, n2r_ff, n2i_ff;

   // wide products with det
   logic signed [PR_W-1:0] p1rr, p1ii, p1ir, p1ri, p2rr, p2ii, p2ir, p2ri;
   logic signed [NUM_W-1:0] num1r_ff, num1i_ff, num2r_ff, num2i_ff;

   logic [DW-1:0]          q1r, q1i, q2r, q2i;
   logic                   s1r, s1i, s2r, s2i;

   logic signed [DW-1:0]   e1r_ff, e1i_ff, e2r_ff, e2i_ff;
   logic [1:0]             st_ff;

   sbs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[PIPE_LAT-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      a1r_ff <= req_alpha1_re;
      a1i_ff <= req_alpha1_im;
      a2r_ff <= req_alpha2_re;
      a2i_ff <= req_alpha2_im;
   end

   // eta1 uses conj(d21) for a left solve, eta2 for a right solve (Hermitian)
   always_ff @(posedge clock) begin
      m22r1r_ff <= smul(cfg.d22_re, a1r_ff);
      m22i1i_ff <= smul(cfg.d22_im, a1i_ff);
      m22r1i_ff <= smul(cfg.d22_re, a1i_ff);
      m22i1r_ff <= smul(cfg.d22_im, a1r_ff);
      mor2r_ff  <= smul(cfg.d21_re, a2r_ff);
      moi2i_ff  <= smul(cfg.d21_im, a2i_ff);
      mor2i_ff  <= smul(cfg.d21_re, a2i_ff);
      moi2r_ff  <= smul(cfg.d21_im, a2r_ff);
      m11r2r_ff <= smul(cfg.d11_re, a2r_ff);
      m11i2i_ff <= smul(cfg.d11_im, a2i_ff);
      m11r2i_ff <= smul(cfg.d11_re, a2i_ff);
      m11i2r_ff <= smul(cfg.d11_im, a2r_ff);
      mor1r_ff  <= smul(cfg.d21_re, a1r_ff);
      moi1i_ff  <= smul(cfg.d21_im, a1i_ff);
      mor1i_ff  <= smul(cfg.d21_re, a1i_ff);
      moi1r_ff  <= smul(cfg.d21_im, a1r_ff);
      cj1_ff    <= cfg.herm && !cfg.rside;
      cj2_ff    <= cfg.herm && cfg.rside;
   end

   always_comb begin
      n1r_in = OP_W'(m22r1r_ff) - OP_W'(m22i1i_ff) - OP_W'(mor2r_ff)
             + (cj1_ff ? -OP_W'(moi2i_ff) : OP_W'(moi2i_ff));
      n1i_in = OP_W'(m22r1i_ff) + OP_W'(m22i1r_ff) - OP_W'(mor2i_ff)
             + (cj1_ff ? OP_W'(moi2r_ff) : -OP_W'(moi2r_ff));
      n2r_in = OP_W'(m11r2r_ff) - OP_W'(m11i2i_ff) - OP_W'(mor1r_ff)
             + (cj2_ff ? -OP_W'(moi1i_ff) : OP_W'(moi1i_ff));
      n2i_in = OP_W'(m11r2i_ff) + OP_W'(m11i2r_ff) - OP_W'(mor1i_ff)
             + (cj2_ff ? OP_W'(moi1r_ff) : -OP_W'(moi1r_ff));
   end

   always_ff @(posedge clock) begin
      n1r_ff <= n1r_in;
      n1i_ff <= n1i_in;
      n2r_ff <= n2r_in;
      n2i_ff <= n2i_in;
   end

   // num * conj(det), one multiplier per product term
   sbs_mul u_m1rr (.clock(clock), .a(n1r_ff), .b(cfg.det_re), .p(p1rr));
   sbs_mul u_m1ii (.clock(clock), .a(n1i_ff), .b(cfg.det_im), .p(p1ii));
   sbs_mul u_m1ir (.clock(clock), .a(n1i_ff), .b(cfg.det_re), .p(p1ir));
   sbs_mul u_m1ri (.clock(clock), .a(n1r_ff), .b(cfg.det_im), .p(p1ri));
   sbs_mul u_m2rr (.clock(clock), .a(n2r_ff), .b(cfg.det_re), .p(p2rr));
   sbs_mul u_m2ii (.clock(clock), .a(n2i_ff), .b(cfg.det_im), .p(p2ii));
   sbs_mul u_m2ir (.clock(clock), .a(n2i_ff), .b(cfg.det_re), .p(p2ir));
   sbs_mul u_m2ri (.clock(clock), .a(n2r_ff), .b(cfg.det_im), .p(p2ri));

   always_ff @(posedge clock) begin
      num1r_ff <= NUM_W'(p1rr) + NUM_W'(p1ii);
      num1i_ff <= NUM_W'(p1ir) - NUM_W'(p1ri);
      num2r_ff <= NUM_W'(p2rr) + NUM_W'(p2ii);
      num2i_ff <= NUM_W'(p2ir) - NUM_W'(p2ri);
   end

   sbs_div #(.FRAC_BITS(FRAC_BITS)) u_d1r (
      .clock(clock), .num(num1r_ff), .den(cfg.den), .res(q1r), .sat(s1r));
   sbs_div #(.FRAC_BITS(FRAC_BITS)) u_d1i (
      .clock(clock), .num(num1i_ff), .den(cfg.den), .res(q1i), .sat(s1i));
   sbs_div #(.FRAC_BITS(FRAC_BITS)) u_d2r (
      .clock(clock), .num(num2r_ff), .den(cfg.den), .res(q2r), .sat(s2r));
   sbs_div #(.FRAC_BITS(FRAC_BITS)) u_d2i (
      .clock(clock), .num(num2i_ff), .den(cfg.den), .res(q2i), .sat(s2i));

   // output register; singular blocks give zeros
   always_ff @(posedge clock) begin
      if (cfg.singular) begin
         e1r_ff <= '0;
         e1i_ff <= '0;
         e2r_ff <= '0;
         e2i_ff <= '0;
         st_ff  <= ST_SINGULAR;
      end else begin
         e1r_ff <= q1r;
         e1i_ff <= q1i;
         e2r_ff <= q2r;
         e2i_ff <= q2i;
         st_ff  <= (s1r || s1i || s2r || s2i) ? ST_SAT : ST_OK;
      end
   end

   assign busy        = busy_ff;
   assign rsp_valid   = vld_ff[PIPE_LAT-1];
   assign rsp_eta1_re = e1r_ff;
   assign rsp_eta1_im = e1i_ff;
   assign rsp_eta2_re = e2r_ff;
   assign rsp_eta2_im = e2i_ff;
   assign rsp_status  = st_ff;

   // every accepted item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_valid)
      else $error("item did not come out after pipeline latency");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SINGULAR) |->
      (rsp_eta1_re == '0 && rsp_eta1_im == '0 && rsp_eta2_re == '0 && rsp_eta2_im == '0))
      else $error("singular result with nonzero data");

   a_sing_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cfg.singular) |-> rsp_status == ST_SINGULAR)
      else $error("singular block not flagged");

endmodule

// ===== src/sbs_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_mul: pipelined signed 66x66 multiplier
// Sign-magnitude split into 33/32-bit slices, four stages.
// ----------------------------------------------------------------------------
module sbs_mul import sbs_pkg::*; (
   input  logic                   clock,
   input  logic signed [OP_W-1:0] a,
   input  logic signed [OP_W-1:0] b,
   output logic signed [PR_W-1:0] p
);

   logic [MAGO_W-1:0]      a_mag_in, b_mag_in, a_mag_ff, b_mag_ff;
   logic                   neg1_ff, neg2_ff, neg3_ff;
   logic [2*LO_W-1:0]      ll_ff;
   logic [LO_W+HI_W-1:0]   lh_ff, hl_ff;
   logic [2*HI_W-1:0]      hh_ff;
   logic [MAG_W-1:0]       sum_in, sum_ff;
   logic signed [PR_W-1:0] p_ff;

   always_comb begin
      a_mag_in = a[OP_W-1] ? MAGO_W'(-a) : MAGO_W'(a);
      b_mag_in = b[OP_W-1] ? MAGO_W'(-b) : MAGO_W'(b);
      sum_in   = MAG_W'(ll_ff) + (MAG_W'(lh_ff) << LO_W) + (MAG_W'(hl_ff) << LO_W)
               + (MAG_W'(hh_ff) << (2 * LO_W));
   end

   always_ff @(posedge clock) begin
      a_mag_ff <= a_mag_in;
      b_mag_ff <= b_mag_in;
      neg1_ff  <= a[OP_W-1] ^ b[OP_W-1];
      ll_ff    <= (2*LO_W)'(a_mag_ff[LO_W-1:0]) * (2*LO_W)'(b_mag_ff[LO_W-1:0]);
      lh_ff    <= (LO_W+HI_W)'(a_mag_ff[LO_W-1:0]) * (LO_W+HI_W)'(b_mag_ff[MAGO_W-1:LO_W]);
      hl_ff    <= (LO_W+HI_W)'(a_mag_ff[MAGO_W-1:LO_W]) * (LO_W+HI_W)'(b_mag_ff[LO_W-1:0]);
      hh_ff    <= (2*HI_W)'(a_mag_ff[MAGO_W-1:LO_W]) * (2*HI_W)'(b_mag_ff[MAGO_W-1:LO_W]);
      neg2_ff  <= neg1_ff;
      sum_ff   <= sum_in;
      neg3_ff  <= neg2_ff;
      p_ff     <= neg3_ff ? -PR_W'(sum_ff) : PR_W'(sum_ff);
   end

   assign p = p_ff;

endmodule

// ===== src/sbs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_div: pipelined restoring divider lane
// round(num * 2^FRAC_BITS / den), ties away from zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
module sbs_div import sbs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic signed [NUM_W-1:0] num,
   input  logic [MAG_W-1:0]        den,
   output logic [DW-1:0]           res,
   output logic                    sat
);

   localparam int W = MAG_W + FRAC_BITS + QB;
   localparam logic [QB:0]   LIM_NEG = (QB+1)'(1) << (DW - 1);
   localparam logic [QB:0]   LIM_POS = LIM_NEG - (QB+1)'(1);
   localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_NEG = ~SAT_POS;

   logic [MAG_W-1:0] mag_in;
   logic [W-1:0]     den_w;
   logic [W-1:0]     n_ff;
   logic             neg0_ff;
   logic [W-1:0]     r_ff   [0:QB];
   logic [QB-1:0]    q_ff   [0:QB];
   logic             neg_ff [0:QB];
   logic             ovf_ff [0:QB];
   logic [W-1:0]     dsh    [0:QB-1];
   logic             ge     [0:QB-1];
   logic             rnd_in, sat_in;
   logic [QB:0]      q1_in;
   logic [DW-1:0]    res_in, res_ff;
   logic             sat_ff;

   always_comb begin
      mag_in = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      den_w  = W'(den);
      for (int k = 0; k < QB; k++) begin
         dsh[k] = den_w << (QB - 1 - k);
         ge[k]  = r_ff[k] >= dsh[k];
      end
      rnd_in = (r_ff[QB] << 1) >= den_w;
      q1_in  = (QB+1)'(q_ff[QB]) + (QB+1)'(rnd_in);
      sat_in = ovf_ff[QB] | (q1_in > (neg_ff[QB] ? LIM_NEG : LIM_POS));
      if (sat_in) begin
         res_in = neg_ff[QB] ? SAT_NEG : SAT_POS;
      end else begin
         res_in = neg_ff[QB] ? -q1_in[DW-1:0] : q1_in[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= W'(mag_in) << FRAC_BITS;
      neg0_ff   <= num[NUM_W-1];
      // quotient of 2^QB or more always saturates
      r_ff[0]   <= n_ff;
      q_ff[0]   <= '0;
      neg_ff[0] <= neg0_ff;
      ovf_ff[0] <= n_ff >= (den_w << QB);
      for (int k = 0; k < QB; k++) begin
         r_ff[k+1]   <= ge[k] ? r_ff[k] - dsh[k] : r_ff[k];
         q_ff[k+1]   <= q_ff[k] | (QB'(ge[k]) << (QB - 1 - k));
         neg_ff[k+1] <= neg_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   assign res = res_ff;
   assign sat = sat_ff;

endmodule

// ===== src/sbs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_cfg: coefficient registers and derived determinant values
// Determinant, |det|^2 and singular flag settle in that order after a write.
// ----------------------------------------------------------------------------
module sbs_cfg import sbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [DW-1:0]    csr_wdata,
   output sbs_cfg_type      cfg
);

   logic signed [DW-1:0]   d11_re_ff, d11_im_ff, d21_re_ff, d21_im_ff, d22_re_ff, d22_im_ff;
   logic                   herm_ff, rside_ff;
   logic signed [DW-1:0]   d11_im_e, d22_im_e;
   logic signed [PP_W-1:0] pa_ff, pb_ff, pc_ff, pd_ff, qa_ff, qb_ff, qc_ff;
   logic signed [OP_W-1:0] det_re_in, det_im_in, det_re_ff, det_im_ff;
   logic signed [PR_W-1:0] sq_re, sq_im;
   logic [MAG_W-1:0]       den_ff;
   logic                   sing_ff;
   logic                   of_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         d11_re_ff <= '0;
         d11_im_ff <= '0;
         d21_re_ff <= '0;
         d21_im_ff <= '0;
         d22_re_ff <= '0;
         d22_im_ff <= '0;
         herm_ff   <= 1'b0;
         rside_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_D11_RE: d11_re_ff <= csr_wdata;
            REG_D11_IM: d11_im_ff <= csr_wdata;
            REG_D21_RE: d21_re_ff <= csr_wdata;
            REG_D21_IM: d21_im_ff <= csr_wdata;
            REG_D22_RE: d22_re_ff <= csr_wdata;
            REG_D22_IM: d22_im_ff <= csr_wdata;
            REG_HERM:   herm_ff   <= csr_wdata[0];
            REG_RSIDE:  rside_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      d11_im_e  = herm_ff ? '0 : d11_im_ff;
      d22_im_e  = herm_ff ? '0 : d22_im_ff;
      of_zero   = (d21_re_ff == '0) && (d21_im_ff == '0);
      // Hermitian: d11*d22 - |d21|^2; symmetric: d11*d22 - d21^2
      det_re_in = OP_W'(pa_ff) - OP_W'(pb_ff) - OP_W'(qa_ff)
                + (herm_ff ? -OP_W'(qb_ff) : OP_W'(qb_ff));
      det_im_in = OP_W'(pc_ff) + OP_W'(pd_ff)
                - (herm_ff ? OP_W'(0) : (OP_W'(qc_ff) <<< 1));
   end

   always_ff @(posedge clock) begin
      pa_ff     <= smul(d11_re_ff, d22_re_ff);
      pb_ff     <= smul(d11_im_e, d22_im_e);
      pc_ff     <= smul(d11_re_ff, d22_im_e);
      pd_ff     <= smul(d11_im_e, d22_re_ff);
      qa_ff     <= smul(d21_re_ff, d21_re_ff);
      qb_ff     <= smul(d21_im_ff, d21_im_ff);
      qc_ff     <= smul(d21_re_ff, d21_im_ff);
      det_re_ff <= det_re_in;
      det_im_ff <= det_im_in;
      den_ff    <= MAG_W'(sq_re) + MAG_W'(sq_im);
      sing_ff   <= (den_ff == '0) || of_zero;
   end

   sbs_mul u_sq_re (
      .clock (clock),
      .a     (det_re_ff),
      .b     (det_re_ff),
      .p     (sq_re)
   );

   sbs_mul u_sq_im (
      .clock (clock),
      .a     (det_im_ff),
      .b     (det_im_ff),
      .p     (sq_im)
   );

   always_comb begin
      cfg.herm     = herm_ff;
      cfg.rside    = rside_ff;
      cfg.d11_re   = d11_re_ff;
      cfg.d11_im   = d11_im_e;
      cfg.d21_re   = d21_re_ff;
      cfg.d21_im   = d21_im_ff;
      cfg.d22_re   = d22_re_ff;
      cfg.d22_im   = d22_im_e;
      cfg.det_re   = det_re_ff;
      cfg.det_im   = det_im_ff;
      cfg.den      = den_ff;
      cfg.singular = sing_ff;
   end

endmodule
